// ===== sv/maf_pkg.sv =====
// Package for the Mahony attitude filter: micro-op format, program and constants
`timescale 1ns / 1ps

package maf_pkg;

  // datapath widths
  localparam int A_W    = 42;
  localparam int B_W    = 36;
  localparam int PROD_W = A_W + B_W;
  localparam int ACC_W  = 66;

  // gyro counts to Q24 rad/s, pi / (180 * 16.4) * 2^40
  localparam logic [30:0] RATE_K = 31'd1170127931;

  // register indexes
  localparam logic [2:0] CFG_KP    = 3'd0;
  localparam logic [2:0] CFG_KI    = 3'd1;
  localparam logic [2:0] CFG_SMOOTH = 3'd2;
  localparam logic [2:0] CFG_BIASX = 3'd3;
  localparam logic [2:0] CFG_BIASY = 3'd4;
  localparam logic [2:0] CFG_BIASZ = 3'd5;
  localparam logic [2:0] CFG_HP    = 3'd6;

  // register reset values
  localparam logic [15:0] KP_RST     = 16'd11141;
  localparam logic [15:0] KI_RST     = 16'd262;
  localparam logic [15:0] SMOOTH_RST = 16'd19661;
  localparam logic [15:0] BIASX_RST  = 16'hFD22;
  localparam logic [15:0] BIASY_RST  = 16'h05A3;
  localparam logic [15:0] BIASZ_RST  = 16'hFCBB;
  localparam logic [31:0] HP_RST     = 32'd4294967;

  // multiplier operand a sources
  localparam logic [3:0] AK_DIFF = 4'd0;
  localparam logic [3:0] AK_GYR  = 4'd1;
  localparam logic [3:0] AK_A8   = 4'd2;
  localparam logic [3:0] AK_Q    = 4'd3;
  localparam logic [3:0] AK_U    = 4'd4;
  localparam logic [3:0] AK_E    = 4'd5;
  localparam logic [3:0] AK_INT  = 4'd6;
  localparam logic [3:0] AK_D    = 4'd7;
  localparam logic [3:0] AK_N    = 4'd8;

  // multiplier operand b sources
  localparam logic [3:0] BK_W     = 4'd0;
  localparam logic [3:0] BK_RATEK = 4'd1;
  localparam logic [3:0] BK_A8    = 4'd2;
  localparam logic [3:0] BK_Q     = 4'd3;
  localparam logic [3:0] BK_V     = 4'd4;
  localparam logic [3:0] BK_HPHI  = 4'd5;
  localparam logic [3:0] BK_HPLO  = 4'd6;
  localparam logic [3:0] BK_KP    = 4'd7;
  localparam logic [3:0] BK_KI    = 4'd8;
  localparam logic [3:0] BK_G     = 4'd9;
  localparam logic [3:0] BK_N     = 4'd10;

  // product shifts
  localparam logic [2:0] SH0  = 3'd0;
  localparam logic [2:0] SH16 = 3'd1;
  localparam logic [2:0] SH24 = 3'd2;
  localparam logic [2:0] SHF  = 3'd3;
  localparam logic [2:0] SH32 = 3'd4;
  localparam logic [2:0] SHG  = 3'd5;

  // accumulator start values
  localparam logic [2:0] BASE_ACC  = 3'd0;
  localparam logic [2:0] BASE_ZERO = 3'd1;
  localparam logic [2:0] BASE_S    = 3'd2;
  localparam logic [2:0] BASE_G    = 3'd3;
  localparam logic [2:0] BASE_INT  = 3'd4;
  localparam logic [2:0] BASE_Q    = 3'd5;

  // result destinations
  localparam logic [2:0] DST_NONE = 3'd0;
  localparam logic [2:0] DST_S    = 3'd1;
  localparam logic [2:0] DST_G    = 3'd2;
  localparam logic [2:0] DST_V    = 3'd3;
  localparam logic [2:0] DST_E    = 3'd4;
  localparam logic [2:0] DST_INT  = 3'd5;
  localparam logic [2:0] DST_D    = 3'd6;
  localparam logic [2:0] DST_N    = 3'd7;

  // program landmarks
  localparam logic [5:0] PC_SQ_END  = 6'd8;
  localparam logic [5:0] PC_DRV_END = 6'd54;
  localparam logic [5:0] PC_LAST    = 6'd58;

  typedef struct packed {
    logic [3:0] ak;
    logic [1:0] ai;
    logic [3:0] bk;
    logic [1:0] bi;
    logic [2:0] sh;
    logic       neg;
    logic       nega;
    logic [2:0] base;
    logic [2:0] dst;
    logic [1:0] di;
    logic       dbl;
  } uop_t;

  function automatic uop_t mk(input logic [3:0] ak, input logic [1:0] ai,
                              input logic [3:0] bk, input logic [1:0] bi,
                              input logic [2:0] sh, input logic neg, input logic nega,
                              input logic [2:0] base, input logic [2:0] dst,
                              input logic [1:0] di, input logic dbl);
    uop_t u;
    u.ak = ak; u.ai = ai; u.bk = bk; u.bi = bi; u.sh = sh; u.neg = neg;
    u.nega = nega; u.base = base; u.dst = dst; u.di = di; u.dbl = dbl;
    return u;
  endfunction

  // multiply-accumulate program
  function automatic uop_t uop_rom(input logic [5:0] pc);
    uop_t u;
    case (pc)
      // accel low-pass
      6'd0:  u = mk(AK_DIFF, 2'd0, BK_W, 2'd0, SH16, 1'b0, 1'b0, BASE_S, DST_S, 2'd0, 1'b0);
      6'd1:  u = mk(AK_DIFF, 2'd1, BK_W, 2'd0, SH16, 1'b0, 1'b0, BASE_S, DST_S, 2'd1, 1'b0);
      6'd2:  u = mk(AK_DIFF, 2'd2, BK_W, 2'd0, SH16, 1'b0, 1'b0, BASE_S, DST_S, 2'd2, 1'b0);
      // gyro scaling
      6'd3:  u = mk(AK_GYR, 2'd0, BK_RATEK, 2'd0, SH24, 1'b0, 1'b0, BASE_ZERO, DST_G, 2'd0, 1'b0);
      6'd4:  u = mk(AK_GYR, 2'd1, BK_RATEK, 2'd0, SH24, 1'b0, 1'b0, BASE_ZERO, DST_G, 2'd1, 1'b0);
      6'd5:  u = mk(AK_GYR, 2'd2, BK_RATEK, 2'd0, SH24, 1'b0, 1'b0, BASE_ZERO, DST_G, 2'd2, 1'b0);
      // accel magnitude squared
      6'd6:  u = mk(AK_A8, 2'd0, BK_A8, 2'd0, SH0, 1'b0, 1'b0, BASE_ZERO, DST_NONE, 2'd0, 1'b0);
      6'd7:  u = mk(AK_A8, 2'd1, BK_A8, 2'd1, SH0, 1'b0, 1'b0, BASE_ACC, DST_NONE, 2'd0, 1'b0);
      6'd8:  u = mk(AK_A8, 2'd2, BK_A8, 2'd2, SH0, 1'b0, 1'b0, BASE_ACC, DST_NONE, 2'd0, 1'b0);
      // gravity direction from the quaternion
      6'd9:  u = mk(AK_Q, 2'd1, BK_Q, 2'd3, SHF, 1'b0, 1'b0, BASE_ZERO, DST_NONE, 2'd0, 1'b0);
      6'd10: u = mk(AK_Q, 2'd0, BK_Q, 2'd2, SHF, 1'b1, 1'b0, BASE_ACC, DST_V, 2'd0, 1'b1);
      6'd11: u = mk(AK_Q, 2'd0, BK_Q, 2'd1, SHF, 1'b0, 1'b0, BASE_ZERO, DST_NONE, 2'd0, 1'b0);
      6'd12: u = mk(AK_Q, 2'd2, BK_Q, 2'd3, SHF, 1'b0, 1'b0, BASE_ACC, DST_V, 2'd1, 1'b1);
      6'd13: u = mk(AK_Q, 2'd0, BK_Q, 2'd0, SHF, 1'b0, 1'b0, BASE_ZERO, DST_NONE, 2'd0, 1'b0);
      6'd14: u = mk(AK_Q, 2'd1, BK_Q, 2'd1, SHF, 1'b1, 1'b0, BASE_ACC, DST_NONE, 2'd0, 1'b0);
      6'd15: u = mk(AK_Q, 2'd2, BK_Q, 2'd2, SHF, 1'b1, 1'b0, BASE_ACC, DST_NONE, 2'd0, 1'b0);
      6'd16: u = mk(AK_Q, 2'd3, BK_Q, 2'd3, SHF, 1'b0, 1'b0, BASE_ACC, DST_V, 2'd2, 1'b0);
      // cross product error
      6'd17: u = mk(AK_U, 2'd1, BK_V, 2'd2, SHF, 1'b0, 1'b0, BASE_ZERO, DST_NONE, 2'd0, 1'b0);
      6'd18: u = mk(AK_U, 2'd2, BK_V, 2'd1, SHF, 1'b1, 1'b0, BASE_ACC, DST_E, 2'd0, 1'b0);
      6'd19: u = mk(AK_U, 2'd2, BK_V, 2'd0, SHF, 1'b0, 1'b0, BASE_ZERO, DST_NONE, 2'd0, 1'b0);
      6'd20: u = mk(AK_U, 2'd0, BK_V, 2'd2, SHF, 1'b1, 1'b0, BASE_ACC, DST_E, 2'd1, 1'b0);
      6'd21: u = mk(AK_U, 2'd0, BK_V, 2'd1, SHF, 1'b0, 1'b0, BASE_ZERO, DST_NONE, 2'd0, 1'b0);
      6'd22: u = mk(AK_U, 2'd1, BK_V, 2'd0, SHF, 1'b1, 1'b0, BASE_ACC, DST_E, 2'd2, 1'b0);
      // integral and PI correction, x
      6'd23: u = mk(AK_E, 2'd0, BK_HPHI, 2'd0, SH16, 1'b0, 1'b0, BASE_INT, DST_NONE, 2'd0, 1'b0);
      6'd24: u = mk(AK_E, 2'd0, BK_HPLO, 2'd0, SH32, 1'b0, 1'b0, BASE_ACC, DST_INT, 2'd0, 1'b0);
      6'd25: u = mk(AK_E, 2'd0, BK_KP, 2'd0, SHG, 1'b0, 1'b0, BASE_G, DST_NONE, 2'd0, 1'b0);
      6'd26: u = mk(AK_INT, 2'd0, BK_KI, 2'd0, SHG, 1'b0, 1'b0, BASE_ACC, DST_G, 2'd0, 1'b0);
      // y
      6'd27: u = mk(AK_E, 2'd1, BK_HPHI, 2'd0, SH16, 1'b0, 1'b0, BASE_INT, DST_NONE, 2'd1, 1'b0);
      6'd28: u = mk(AK_E, 2'd1, BK_HPLO, 2'd0, SH32, 1'b0, 1'b0, BASE_ACC, DST_INT, 2'd1, 1'b0);
      6'd29: u = mk(AK_E, 2'd1, BK_KP, 2'd0, SHG, 1'b0, 1'b0, BASE_G, DST_NONE, 2'd1, 1'b0);
      6'd30: u = mk(AK_INT, 2'd1, BK_KI, 2'd0, SHG, 1'b0, 1'b0, BASE_ACC, DST_G, 2'd1, 1'b0);
      // z
      6'd31: u = mk(AK_E, 2'd2, BK_HPHI, 2'd0, SH16, 1'b0, 1'b0, BASE_INT, DST_NONE, 2'd2, 1'b0);
      6'd32: u = mk(AK_E, 2'd2, BK_HPLO, 2'd0, SH32, 1'b0, 1'b0, BASE_ACC, DST_INT, 2'd2, 1'b0);
      6'd33: u = mk(AK_E, 2'd2, BK_KP, 2'd0, SHG, 1'b0, 1'b0, BASE_G, DST_NONE, 2'd2, 1'b0);
      6'd34: u = mk(AK_INT, 2'd2, BK_KI, 2'd0, SHG, 1'b0, 1'b0, BASE_ACC, DST_G, 2'd2, 1'b0);
      // quaternion w
      6'd35: u = mk(AK_Q, 2'd1, BK_G, 2'd0, SH24, 1'b0, 1'b1, BASE_ZERO, DST_NONE, 2'd0, 1'b0);
      6'd36: u = mk(AK_Q, 2'd2, BK_G, 2'd1, SH24, 1'b1, 1'b0, BASE_ACC, DST_NONE, 2'd0, 1'b0);
      6'd37: u = mk(AK_Q, 2'd3, BK_G, 2'd2, SH24, 1'b1, 1'b0, BASE_ACC, DST_D, 2'd0, 1'b0);
      6'd38: u = mk(AK_D, 2'd0, BK_HPHI, 2'd0, SH16, 1'b0, 1'b0, BASE_Q, DST_NONE, 2'd0, 1'b0);
      6'd39: u = mk(AK_D, 2'd0, BK_HPLO, 2'd0, SH32, 1'b0, 1'b0, BASE_ACC, DST_N, 2'd0, 1'b0);
      // quaternion x
      6'd40: u = mk(AK_Q, 2'd0, BK_G, 2'd0, SH24, 1'b0, 1'b0, BASE_ZERO, DST_NONE, 2'd0, 1'b0);
      6'd41: u = mk(AK_Q, 2'd2, BK_G, 2'd2, SH24, 1'b0, 1'b0, BASE_ACC, DST_NONE, 2'd0, 1'b0);
      6'd42: u = mk(AK_Q, 2'd3, BK_G, 2'd1, SH24, 1'b1, 1'b0, BASE_ACC, DST_D, 2'd0, 1'b0);
      6'd43: u = mk(AK_D, 2'd0, BK_HPHI, 2'd0, SH16, 1'b0, 1'b0, BASE_Q, DST_NONE, 2'd1, 1'b0);
      6'd44: u = mk(AK_D, 2'd0, BK_HPLO, 2'd0, SH32, 1'b0, 1'b0, BASE_ACC, DST_N, 2'd1, 1'b0);
      // quaternion y
      6'd45: u = mk(AK_Q, 2'd0, BK_G, 2'd1, SH24, 1'b0, 1'b0, BASE_ZERO, DST_NONE, 2'd0, 1'b0);
      6'd46: u = mk(AK_Q, 2'd1, BK_G, 2'd2, SH24, 1'b1, 1'b0, BASE_ACC, DST_NONE, 2'd0, 1'b0);
      6'd47: u = mk(AK_Q, 2'd3, BK_G, 2'd0, SH24, 1'b0, 1'b0, BASE_ACC, DST_D, 2'd0, 1'b0);
      6'd48: u = mk(AK_D, 2'd0, BK_HPHI, 2'd0, SH16, 1'b0, 1'b0, BASE_Q, DST_NONE, 2'd2, 1'b0);
      6'd49: u = mk(AK_D, 2'd0, BK_HPLO, 2'd0, SH32, 1'b0, 1'b0, BASE_ACC, DST_N, 2'd2, 1'b0);
      // quaternion z
      6'd50: u = mk(AK_Q, 2'd0, BK_G, 2'd2, SH24, 1'b0, 1'b0, BASE_ZERO, DST_NONE, 2'd0, 1'b0);
      6'd51: u = mk(AK_Q, 2'd1, BK_G, 2'd1, SH24, 1'b0, 1'b0, BASE_ACC, DST_NONE, 2'd0, 1'b0);
      6'd52: u = mk(AK_Q, 2'd2, BK_G, 2'd0, SH24, 1'b1, 1'b0, BASE_ACC, DST_D, 2'd0, 1'b0);
      6'd53: u = mk(AK_D, 2'd0, BK_HPHI, 2'd0, SH16, 1'b0, 1'b0, BASE_Q, DST_NONE, 2'd3, 1'b0);
      6'd54: u = mk(AK_D, 2'd0, BK_HPLO, 2'd0, SH32, 1'b0, 1'b0, BASE_ACC, DST_N, 2'd3, 1'b0);
      // quaternion norm squared
      6'd55: u = mk(AK_N, 2'd0, BK_N, 2'd0, SH0, 1'b0, 1'b0, BASE_ZERO, DST_NONE, 2'd0, 1'b0);
      6'd56: u = mk(AK_N, 2'd1, BK_N, 2'd1, SH0, 1'b0, 1'b0, BASE_ACC, DST_NONE, 2'd0, 1'b0);
      6'd57: u = mk(AK_N, 2'd2, BK_N, 2'd2, SH0, 1'b0, 1'b0, BASE_ACC, DST_NONE, 2'd0, 1'b0);
      6'd58: u = mk(AK_N, 2'd3, BK_N, 2'd3, SH0, 1'b0, 1'b0, BASE_ACC, DST_NONE, 2'd0, 1'b0);
      default: u = mk(AK_Q, 2'd0, BK_Q, 2'd0, SH0, 1'b0, 1'b0, BASE_ACC, DST_NONE, 2'd0, 1'b0);
    endcase
    return u;
  endfunction

endpackage

// ===== sv/mahony_attitude_filter_top.sv =====
// Mahony attitude filter top level: sequencer, shared multiplier, square root and divider
`timescale 1ns / 1ps

// One IMU sample in, one renormalized attitude quaternion out. A single signed
// 22x36 multiplier forms each 42x36 product in two passes, upper half of operand
// a first; each step of the 59-step multiply-accumulate program passes through the
// MUL, MUL2 and ACC states. A bit-serial square root and a restoring divider
// handle normalization of the accel vector and of the quaternion, which is first
// shifted down until its largest component fits. The input is not ready while a
// sample is in progress. The output register lets the next sample start while a
// finished quaternion waits. Configuration registers may be written at any time
// the block is idle; index 7 is ignored.
module mahony_attitude_filter_top #(
  parameter int QUAT_FRAC_BITS = 30
) (
  input  logic         clk,
  input  logic         rst_n,
  // input items
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // gyro_raw_x, gyro_raw_y, gyro_raw_z, accel_x, accel_y, accel_z
  // result items
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // quat_w, quat_x, quat_y, quat_z
  // configuration writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_data
);
  import maf_pkg::*;

  localparam int          FB       = QUAT_FRAC_BITS;
  localparam logic [4:0]  DIV_LAST = 5'(FB);
  localparam logic [31:0] Q_ONE    = 32'(64'd1 << FB);
  localparam int          A_LO     = A_W / 2;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MUL   = 4'd1;
  localparam logic [3:0] ST_ACC   = 4'd2;
  localparam logic [3:0] ST_SQRT  = 4'd3;
  localparam logic [3:0] ST_DIVLD = 4'd4;
  localparam logic [3:0] ST_DIV   = 4'd5;
  localparam logic [3:0] ST_MAX   = 4'd6;
  localparam logic [3:0] ST_SHIFT = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;
  localparam logic [3:0] ST_MUL2  = 4'd9;

  // control
  logic [3:0] state_r;
  logic [5:0] pc_r;
  logic [4:0] cnt_r;
  logic [1:0] j_r;
  logic       out_valid_r;

  // configuration
  logic [15:0] kp_r, ki_r, smooth_r;
  logic signed [15:0] bias_r [3];
  logic [31:0] hp_r;

  // filter state
  logic signed [31:0] q_r   [4];
  logic signed [31:0] int_r [3];
  logic signed [31:0] s_r   [3];

  // working registers
  logic signed [15:0] gyro_in_r [3];
  logic signed [15:0] acc_in_r  [3];
  logic signed [23:0] a8_r [3];
  logic signed [35:0] g_r  [3];
  logic signed [31:0] u_r  [3];
  logic signed [35:0] v_r  [3];
  logic signed [35:0] e_r  [3];
  logic signed [41:0] d_r;
  logic signed [41:0] n_r  [4];
  logic [41:0]        m_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [63:0]  sv_r, sr_r;
  logic [31:0]  root_r;
  logic [32:0]  rem_r;
  logic [30:0]  quo_r;
  logic         sign_r;
  logic [127:0] out_data_r;

  uop_t op;
  logic signed [A_W-1:0]    a_val, a_op;
  logic signed [B_W-1:0]    b_op;
  logic signed [A_W-A_LO:0] mul_a;
  logic signed [A_W-A_LO+B_W:0] mul_p;
  logic signed [PROD_W-1:0] shifted;
  logic signed [ACC_W-1:0]  term, base, acc_nxt, dbl_val;
  logic signed [31:0]       sat_val;
  logic [63:0]  sbit, rb, sr_nxt, sv_nxt;
  logic [5:0]   shamt;
  logic         quat_ph;
  logic [1:0]   aj;
  logic signed [41:0] dx, dx_abs;
  logic         cmp;
  logic [32:0]  r1;
  logic [30:0]  quo_nxt;
  logic signed [31:0] div_res;
  logic [41:0]  abs_n [4];
  logic [41:0]  m_nxt;
  logic         out_load;

  assign op      = uop_rom(pc_r);
  assign quat_ph = (pc_r == PC_LAST + 6'd1);
  assign aj      = (j_r == 2'd3) ? 2'd0 : j_r;

  // multiplier operand a
  always_comb begin
    case (op.ak)
      AK_DIFF: a_val = A_W'(34'(signed'({acc_in_r[op.ai], 16'h0000})) - 34'(s_r[op.ai]));
      AK_GYR:  a_val = A_W'((25'(gyro_in_r[op.ai]) <<< 8) - 25'(bias_r[op.ai]));
      AK_A8:   a_val = A_W'(a8_r[op.ai]);
      AK_Q:    a_val = A_W'(q_r[op.ai]);
      AK_U:    a_val = A_W'(u_r[op.ai]);
      AK_E:    a_val = A_W'(e_r[op.ai]);
      AK_INT:  a_val = A_W'(int_r[op.ai]);
      AK_D:    a_val = d_r;
      AK_N:    a_val = n_r[op.ai];
      default: a_val = '0;
    endcase
    a_op = op.nega ? -a_val : a_val;
  end

  // multiplier operand b
  always_comb begin
    case (op.bk)
      BK_W:     b_op = signed'(B_W'(smooth_r));
      BK_RATEK: b_op = signed'(B_W'(RATE_K));
      BK_A8:    b_op = B_W'(a8_r[op.bi]);
      BK_Q:     b_op = B_W'(q_r[op.bi]);
      BK_V:     b_op = v_r[op.bi];
      BK_HPHI:  b_op = signed'(B_W'(hp_r[31:16]));
      BK_HPLO:  b_op = signed'(B_W'(hp_r[15:0]));
      BK_KP:    b_op = signed'(B_W'(kp_r));
      BK_KI:    b_op = signed'(B_W'(ki_r));
      BK_G:     b_op = g_r[op.bi];
      BK_N:     b_op = B_W'(n_r[op.bi]);
      default:  b_op = '0;
    endcase
  end

  // shared multiplier, upper half of operand a first, then the lower half
  always_comb begin
    if (state_r == ST_MUL2) mul_a = signed'({1'b0, a_op[A_LO-1:0]});
    else                    mul_a = signed'({a_op[A_W-1], a_op[A_W-1:A_LO]});
    mul_p = mul_a * b_op;
  end

  // product shift, sign and accumulate
  always_comb begin
    case (op.sh)
      SH0:     shifted = prod_r;
      SH16:    shifted = prod_r >>> 16;
      SH24:    shifted = prod_r >>> 24;
      SHF:     shifted = prod_r >>> FB;
      SH32:    shifted = prod_r >>> 32;
      SHG:     shifted = prod_r >>> (FB - 8);
      default: shifted = prod_r;
    endcase
    term = ACC_W'(shifted);
    if (op.neg) term = -term;
    case (op.base)
      BASE_ACC:  base = acc_r;
      BASE_ZERO: base = '0;
      BASE_S:    base = ACC_W'(s_r[op.di]);
      BASE_G:    base = ACC_W'(g_r[op.di]);
      BASE_INT:  base = ACC_W'(int_r[op.di]);
      BASE_Q:    base = ACC_W'(q_r[op.di]);
      default:   base = '0;
    endcase
    acc_nxt = base + term;
    dbl_val = op.dbl ? (acc_nxt <<< 1) : acc_nxt;
    if (acc_nxt > ACC_W'(33'sh0_7FFF_FFFF))      sat_val = 32'sh7FFF_FFFF;
    else if (acc_nxt < -ACC_W'(33'sh0_8000_0000)) sat_val = 32'sh8000_0000;
    else                                          sat_val = acc_nxt[31:0];
  end

  // square root step
  always_comb begin
    shamt = 6'd62 - {cnt_r, 1'b0};
    sbit  = 64'd1 << shamt;
    rb    = sr_r + sbit;
    if (sv_r >= rb) begin
      sv_nxt = sv_r - rb;
      sr_nxt = (sr_r >> 1) + sbit;
    end else begin
      sv_nxt = sv_r;
      sr_nxt = sr_r >> 1;
    end
  end

  // divider step and operand
  always_comb begin
    dx      = quat_ph ? n_r[j_r] : 42'(a8_r[aj]);
    dx_abs  = (dx < 0) ? -dx : dx;
    cmp     = rem_r >= {1'b0, root_r};
    r1      = cmp ? rem_r - {1'b0, root_r} : rem_r;
    quo_nxt = {quo_r[29:0], cmp};
    div_res = sign_r ? -32'(quo_nxt) : 32'(quo_nxt);
  end

  // largest quaternion magnitude
  always_comb begin
    for (int k = 0; k < 4; k++) abs_n[k] = (n_r[k] < 0) ? 42'(-n_r[k]) : 42'(n_r[k]);
    m_nxt = abs_n[0];
    for (int k = 1; k < 4; k++) if (abs_n[k] > m_nxt) m_nxt = abs_n[k];
  end

  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  // result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      cnt_r       <= '0;
      j_r         <= '0;
      kp_r        <= KP_RST;
      ki_r        <= KI_RST;
      smooth_r    <= SMOOTH_RST;
      bias_r[0]   <= BIASX_RST;
      bias_r[1]   <= BIASY_RST;
      bias_r[2]   <= BIASZ_RST;
      hp_r        <= HP_RST;
      q_r[0]      <= Q_ONE;
      for (int k = 1; k < 4; k++) q_r[k] <= '0;
      for (int k = 0; k < 3; k++) begin
        int_r[k] <= '0;
        s_r[k]   <= '0;
      end
    end else begin
      // register writes
      if (cfg_valid) begin
        case (cfg_addr)
          CFG_KP:     kp_r      <= cfg_data[15:0];
          CFG_KI:     ki_r      <= cfg_data[15:0];
          CFG_SMOOTH: smooth_r  <= cfg_data[15:0];
          CFG_BIASX:  bias_r[0] <= cfg_data[15:0];
          CFG_BIASY:  bias_r[1] <= cfg_data[15:0];
          CFG_BIASZ:  bias_r[2] <= cfg_data[15:0];
          CFG_HP:     hp_r      <= cfg_data;
          default: ;
        endcase
      end

      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            for (int k = 0; k < 3; k++) begin
              gyro_in_r[k] <= in_tdata[16*k +: 16];
              acc_in_r[k]  <= in_tdata[48 + 16*k +: 16];
            end
            pc_r    <= '0;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_r  <= PROD_W'(mul_p);
          state_r <= ST_MUL2;
        end
        ST_MUL2: begin
          prod_r  <= (prod_r <<< A_LO) + PROD_W'(mul_p);
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          acc_r <= acc_nxt;
          case (op.dst)
            DST_S: begin
              s_r[op.di]  <= acc_nxt[31:0];
              a8_r[op.di] <= acc_nxt[31:8];
            end
            DST_G:   g_r[op.di]   <= acc_nxt[35:0];
            DST_V:   v_r[op.di]   <= dbl_val[35:0];
            DST_E:   e_r[op.di]   <= acc_nxt[35:0];
            DST_INT: int_r[op.di] <= sat_val;
            DST_D:   d_r          <= acc_nxt[41:0];
            DST_N:   n_r[op.di]   <= acc_nxt[41:0];
            default: ;
          endcase
          pc_r <= pc_r + 6'd1;
          if (pc_r == PC_SQ_END || pc_r == PC_LAST) begin
            sv_r    <= acc_nxt[63:0];
            sr_r    <= '0;
            cnt_r   <= '0;
            state_r <= ST_SQRT;
          end else if (pc_r == PC_DRV_END) begin
            state_r <= ST_MAX;
          end else begin
            state_r <= ST_MUL;
          end
        end
        ST_SQRT: begin
          sv_r  <= sv_nxt;
          sr_r  <= sr_nxt;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            root_r  <= sr_nxt[31:0];
            j_r     <= '0;
            state_r <= ST_DIVLD;
          end
        end
        ST_DIVLD: begin
          if (root_r == '0) begin
            // zero accel gives zero correction, vanishing quaternion is held
            if (quat_ph) begin
              state_r <= ST_OUT;
            end else begin
              for (int k = 0; k < 3; k++) u_r[k] <= '0;
              state_r <= ST_MUL;
            end
          end else begin
            sign_r  <= dx < 0;
            rem_r   <= dx_abs[32:0];
            quo_r   <= '0;
            cnt_r   <= '0;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r <= {r1[31:0], 1'b0};
          quo_r <= quo_nxt;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == DIV_LAST) begin
            j_r <= j_r + 2'd1;
            if (quat_ph) begin
              q_r[j_r] <= div_res;
              state_r  <= (j_r == 2'd3) ? ST_OUT : ST_DIVLD;
            end else begin
              u_r[aj] <= div_res;
              state_r <= (j_r == 2'd2) ? ST_MUL : ST_DIVLD;
            end
          end
        end
        ST_MAX: begin
          m_r     <= m_nxt;
          state_r <= ST_SHIFT;
        end
        ST_SHIFT: begin
          // shift all components together until the largest fits in 30 bits
          if (m_r[41:30] != '0) begin
            m_r <= m_r >> 1;
            for (int k = 0; k < 4; k++) n_r[k] <= n_r[k] >>> 1;
          end else begin
            state_r <= ST_MUL;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            out_data_r  <= {q_r[3], q_r[2], q_r[1], q_r[0]};
            pc_r        <= '0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a sample is in progress");

  a_idle_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (pc_r == '0))
    else $error("program counter not rewound at idle");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r <= DIV_LAST))
    else $error("divider ran past the last quotient bit");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && (!out_valid_r || out_tready)) |=> out_tvalid)
    else $error("finished quaternion not presented");

endmodule

// ===== dv/testbench.sv =====
// Testbench for the Mahony attitude filter: scoreboard with an attitude predictor, stream drivers
`timescale 1ns / 1ps

// tracks the filter state and the queue of predicted quaternions
class attitude_scoreboard;
  localparam int FB = 30;
  localparam longint RATE_GAIN = 64'd1170127931;

  logic [15:0] kp, ki, smooth;
  logic signed [15:0] bias [3];
  logic [31:0] hp;
  int quat [4];
  int integ_err [3];
  int accel_lp [3];
  logic [127:0] quat_queue [$];
  int errors;

  function new();
    kp = 16'd11141; ki = 16'd262; smooth = 16'd19661;
    bias[0] = -16'sd734; bias[1] = 16'sd1443; bias[2] = -16'sd837;
    hp = 32'd4294967;
    quat[0] = 1 << FB; quat[1] = 0; quat[2] = 0; quat[3] = 0;
    for (int i = 0; i < 3; i++) begin
      integ_err[i] = 0;
      accel_lp[i] = 0;
    end
    errors = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      maf_pkg::CFG_KP: kp = val[15:0];
      maf_pkg::CFG_KI: ki = val[15:0];
      maf_pkg::CFG_SMOOTH: smooth = val[15:0];
      maf_pkg::CFG_BIASX: bias[0] = val[15:0];
      maf_pkg::CFG_BIASY: bias[1] = val[15:0];
      maf_pkg::CFG_BIASZ: bias[2] = val[15:0];
      maf_pkg::CFG_HP: hp = val;
      default: ;
    endcase
  endfunction

  function longint fmul(longint a, longint b);
    return (a * b) >>> FB;
  endfunction

  function longint scale_hp(longint r);
    return ((r * longint'(hp[31:16])) >>> 16) + ((r * longint'(hp[15:0])) >>> 32);
  endfunction

  function longint sat(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // predict the quaternion caused by one accepted sample
  function void note_sample(logic [95:0] d);
    longint g [3];
    longint a8 [3];
    longint u [3];
    longint v [3];
    longint e [3];
    longint q [4];
    longint n [4];
    longint s, diff, acc, root, m, a, one;
    longint unsigned sum;
    int sh;
    one = longint'(1) << FB;
    for (int i = 0; i < 4; i++) q[i] = quat[i];
    // accel low-pass and gyro scaling
    for (int i = 0; i < 3; i++) begin
      s = accel_lp[i];
      diff = longint'($signed(d[48 + 16 * i +: 16])) * 65536 - s;
      s = s + ((diff * longint'(smooth)) >>> 16);
      accel_lp[i] = int'(s);
      a8[i] = s >>> 8;
      g[i] = ((longint'($signed(d[16 * i +: 16])) * 256 - longint'(bias[i])) * RATE_GAIN) >>> 24;
    end
    // unit accel, zero when the filtered vector vanishes
    sum = longint'(a8[0] * a8[0]) + longint'(a8[1] * a8[1]) + longint'(a8[2] * a8[2]);
    root = longint'(int_sqrt(sum));
    for (int i = 0; i < 3; i++) u[i] = (root != 0) ? (a8[i] * one) / root : 0;
    // gravity direction and error
    v[0] = 2 * (fmul(q[1], q[3]) - fmul(q[0], q[2]));
    v[1] = 2 * (fmul(q[0], q[1]) + fmul(q[2], q[3]));
    v[2] = fmul(q[0], q[0]) - fmul(q[1], q[1]) - fmul(q[2], q[2]) + fmul(q[3], q[3]);
    e[0] = fmul(u[1], v[2]) - fmul(u[2], v[1]);
    e[1] = fmul(u[2], v[0]) - fmul(u[0], v[2]);
    e[2] = fmul(u[0], v[1]) - fmul(u[1], v[0]);
    // pi correction with saturating integral
    for (int i = 0; i < 3; i++) begin
      acc = sat(longint'(integ_err[i]) + scale_hp(e[i]));
      integ_err[i] = int'(acc);
      g[i] = g[i] + ((longint'(kp) * e[i]) >>> (FB - 8)) + ((longint'(ki) * acc) >>> (FB - 8));
    end
    // euler step from the previous components
    n[0] = q[0] + scale_hp(((-q[1] * g[0]) >>> 24) - ((q[2] * g[1]) >>> 24)
                           - ((q[3] * g[2]) >>> 24));
    n[1] = q[1] + scale_hp(((q[0] * g[0]) >>> 24) + ((q[2] * g[2]) >>> 24)
                           - ((q[3] * g[1]) >>> 24));
    n[2] = q[2] + scale_hp(((q[0] * g[1]) >>> 24) - ((q[1] * g[2]) >>> 24)
                           + ((q[3] * g[0]) >>> 24));
    n[3] = q[3] + scale_hp(((q[0] * g[2]) >>> 24) + ((q[1] * g[1]) >>> 24)
                           - ((q[2] * g[0]) >>> 24));
    // renormalize, hold on a vanishing quaternion
    m = 0;
    for (int i = 0; i < 4; i++) begin
      a = (n[i] < 0) ? -n[i] : n[i];
      if (a > m) m = a;
    end
    sh = 0;
    while (sh < 62 && (m >> sh) >= (longint'(1) << 30)) sh++;
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      n[i] = n[i] >>> sh;
      sum = sum + longint'(n[i] * n[i]);
    end
    root = longint'(int_sqrt(sum));
    if (root != 0)
      for (int i = 0; i < 4; i++) quat[i] = int'(sat((n[i] * one) / root));
    quat_queue.push_back({quat[3], quat[2], quat[1], quat[0]});
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task check_quat(logic [127:0] got);
    logic [127:0] want;
    if (quat_queue.size() == 0) begin
      report($sformatf("unexpected quaternion %h", got));
      return;
    end
    want = quat_queue.pop_front();
    for (int i = 0; i < 4; i++)
      if (got[32 * i +: 32] !== want[32 * i +: 32])
        report($sformatf("component %0d got %h want %h", i, got[32 * i +: 32],
                         want[32 * i +: 32]));
  endtask
endclass

module testbench;
  localparam longint CYCLE_LIMIT = 6000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [95:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_addr = '0;
  logic [31:0] cfg_data = '0;
  logic calm = 1'b0;
  longint cycles = 0;
  attitude_scoreboard sb = new();

  mahony_attitude_filter_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // watch handshakes and the cycle budget
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_addr, cfg_data);
      if (in_tvalid && in_tready) sb.note_sample(in_tdata);
      if (out_tvalid && out_tready) sb.check_quat(out_tdata);
    end
  end

  // result-side stalls
  always @(posedge clk)
    out_tready <= calm || ($urandom_range(99) >= 38);

  task automatic send_sample(logic [95:0] d);
    if (!calm && $urandom_range(99) < 38) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.quat_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(logic [15:0] k_p, logic [15:0] k_i, logic [15:0] w,
                           logic [15:0] bx, logic [15:0] by, logic [15:0] bz,
                           logic [31:0] h);
    wait_idle();
    write_reg(maf_pkg::CFG_KP, {16'd0, k_p});
    write_reg(maf_pkg::CFG_KI, {16'd0, k_i});
    write_reg(maf_pkg::CFG_SMOOTH, {16'd0, w});
    write_reg(maf_pkg::CFG_BIASX, {16'hFFFF, bx});
    write_reg(maf_pkg::CFG_BIASY, {16'd0, by});
    write_reg(maf_pkg::CFG_BIASZ, {16'd0, bz});
    write_reg(maf_pkg::CFG_HP, h);
  endtask

  function automatic logic [15:0] gyro_pick();
    if ($urandom_range(99) < 20) return 16'($urandom);
    return 16'($signed($urandom_range(0, 1200)) - 600);
  endfunction

  function automatic logic [95:0] random_sample();
    logic [15:0] ax, ay, az;
    int kind;
    kind = $urandom_range(99);
    if (kind < 60) begin
      // near gravity with noise
      ax = 16'($signed($urandom_range(0, 2000)) - 1000);
      ay = 16'($signed($urandom_range(0, 2000)) - 1000);
      az = 16'(4096 + $signed($urandom_range(0, 2000)) - 1000);
    end else if (kind < 70) begin
      ax = '0; ay = '0; az = '0;
    end else begin
      ax = 16'($urandom); ay = 16'($urandom); az = 16'($urandom);
    end
    return {az, ay, ax, gyro_pick(), gyro_pick(), gyro_pick()};
  endfunction

  initial begin
    int phases;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero accel first, then field extremes
    send_sample('0);
    send_sample({16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF});
    send_sample({16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000});
    send_sample({16'h1000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
    send_sample({16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
    send_sample({16'hFFFF, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0001});
    // unknown register index is ignored
    wait_idle();
    write_reg(3'd7, 32'hFFFFFFFF);
    send_sample({16'h1000, 16'h0100, 16'h0100, 16'h0010, 16'hFFF0, 16'h0020});
    // maximal gains and period drive the integral into saturation
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 32'hFFFFFFFF);
    for (int i = 0; i < 10; i++)
      send_sample({16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF});
    write_all(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0);
    send_sample({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
    send_sample(random_sample());

    // random phases over several register settings
    phases = 8;
    for (int p = 0; p < phases; p++) begin
      case (p)
        0: write_all(16'd11141, 16'd262, 16'd19661, 16'hFD22, 16'h05A3, 16'hFCBB, 32'd4294967);
        1: write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000, 32'hFFFFFFFF);
        2: write_all(16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 32'h0);
        default: write_all(16'($urandom), 16'($urandom_range(0, 4000)), 16'($urandom),
                           16'($urandom), 16'($urandom), 16'($urandom),
                           (p % 2) ? $urandom : $urandom_range(0, 50000000));
      endcase
      calm <= (p == 4);
      for (int i = 0; i < 240; i++) send_sample(random_sample());
      calm <= 1'b0;
    end

    in_tvalid <= 1'b0;
    while (sb.quat_queue.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
sv/maf_pkg.sv
sv/mahony_attitude_filter_top.sv
dv/testbench.sv
